### rtl/core/bcss_pkg.sv
// Package for the button counter with seven-segment display.
// Holds the shared widths, the FIFO transfer types and the BCD and segment helpers.
// No dependencies.
package bcss_pkg;

    localparam int COUNT_W          = 32;
    localparam int EDGE_W           = 4;
    localparam int SWITCH_W         = 10;
    localparam int SEG_LOW_W        = 32;
    localparam int SEG_HIGH_W       = 16;
    localparam int DIGITS           = 6;
    localparam int BIN_W            = 20;
    localparam int BCD_W            = 4 * DIGITS;
    localparam int DD_W             = BCD_W + BIN_W;
    localparam int SHIFTS_PER_STAGE = 4;
    localparam int DABBLE_STAGES    = BIN_W / SHIFTS_PER_STAGE;
    localparam int DEF_FIFO_DEPTH   = 4;

    localparam logic [BIN_W-1:0] DISPLAY_MAX = BIN_W'(999999);

    localparam int EDGE_INC_BIT  = 0;
    localparam int EDGE_LOAD_BIT = 1;

    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] count;
    } bcss_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } bcss_fifo_stat_t;

    function automatic logic [BIN_W-1:0] saturate(input logic [COUNT_W-1:0] c);
        logic [BIN_W-1:0] r;
        if (c > COUNT_W'(DISPLAY_MAX)) begin
            r = DISPLAY_MAX;
        end else begin
            r = c[BIN_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [DD_W-1:0] dabble_step(input logic [DD_W-1:0] x);
        logic [DD_W-1:0] y;
        logic [3:0]      d;
        y = x;
        for (int k = 0; k < DIGITS; k++) begin
            d = y[BIN_W + 4*k +: 4];
            if (d >= 4'd5) begin
                y[BIN_W + 4*k +: 4] = d + 4'd3;
            end
        end
        return {y[DD_W-2:0], 1'b0};
    endfunction

    function automatic logic [DD_W-1:0] dabble_group(input logic [DD_W-1:0] x);
        logic [DD_W-1:0] y;
        y = x;
        for (int s = 0; s < SHIFTS_PER_STAGE; s++) begin
            y = dabble_step(y);
        end
        return y;
    endfunction

    function automatic logic [7:0] seg_code(input logic [3:0] d);
        logic [7:0] r;
        case (d)
            4'd0: r = 8'h3F;
            4'd1: r = 8'h06;
            4'd2: r = 8'h5B;
            4'd3: r = 8'h4F;
            4'd4: r = 8'h66;
            4'd5: r = 8'h6D;
            4'd6: r = 8'h7D;
            4'd7: r = 8'h07;
            4'd8: r = 8'h7F;
            4'd9: r = 8'h6F;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/bcss_front.sv
// Front end: accepts button events, classifies them and updates the event count.
// Pushes the new count into the FIFO for every event that produces a display word.
// Depends on bcss_pkg.
module bcss_front
    import bcss_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [EDGE_W-1:0]   s_edge_bits,
    input  logic [SWITCH_W-1:0] s_switch_value,
    input  bcss_fifo_stat_t     fifo_stat,
    output bcss_push_t          push
);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               take;
    logic               is_inc;
    logic               is_load;

    assign s_ready = !fifo_stat.full;
    assign take    = s_valid && s_ready;
    assign is_inc  = s_edge_bits[EDGE_INC_BIT];
    assign is_load = s_edge_bits[EDGE_LOAD_BIT];

    always_comb begin
        count_next = count_reg;
        if (take && is_inc) begin
            count_next = count_reg + COUNT_W'(1);
        end else if (take && is_load) begin
            count_next = COUNT_W'(s_switch_value);
        end
    end

    assign push.valid = take && (is_inc || is_load);
    assign push.count = count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

### rtl/core/bcss_fifo.sv
// Short FIFO of count values between the front end and the display pipeline.
// Flip-flop storage, one push and one pop port.
// Depends on bcss_pkg.
module bcss_fifo
    import bcss_pkg::*;
#(
    parameter int DEPTH = DEF_FIFO_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  bcss_push_t         push,
    input  logic               pop,
    output logic [COUNT_W-1:0] head_count,
    output bcss_fifo_stat_t    stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [COUNT_W-1:0] mem_reg [DEPTH];
    logic [AW-1:0]      wr_ptr_reg;
    logic [AW-1:0]      rd_ptr_reg;
    logic [CW-1:0]      cnt_reg;
    logic               do_push;
    logic               do_pop;

    assign stat.full  = (cnt_reg == CW'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign head_count = mem_reg[rd_ptr_reg];
    assign do_push    = push.valid && !stat.full;
    assign do_pop     = pop && !stat.empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push.count;
        end
    end

endmodule

### rtl/core/bcss_back.sv
// Back end: saturates the count, converts it to six BCD digits by a pipelined
// shift-and-add-three, and encodes each digit into a seven-segment byte.
// Depends on bcss_pkg.
module bcss_back
    import bcss_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  head_valid,
    input  logic [COUNT_W-1:0]    head_count,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SEG_LOW_W-1:0]  m_seg_low_word,
    output logic [SEG_HIGH_W-1:0] m_seg_high_word
);

    localparam int NST = DABBLE_STAGES + 1;

    logic [NST-1:0]        vld_reg;
    logic [DD_W-1:0]       dd_reg [NST];
    logic                  out_vld_reg;
    logic [SEG_LOW_W-1:0]  seg_low_reg;
    logic [SEG_HIGH_W-1:0] seg_high_reg;
    logic [NST:0]          adv;
    logic [BCD_W-1:0]      bcd;

    always_comb begin
        adv[NST] = !out_vld_reg || m_ready;
        for (int i = NST - 1; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign pop = head_valid && adv[0];
    assign bcd = dd_reg[NST-1][DD_W-1 -: BCD_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= head_valid;
            end
            for (int i = 1; i < NST; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
            if (adv[NST]) begin
                out_vld_reg <= vld_reg[NST-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0] && head_valid) begin
            dd_reg[0] <= {{BCD_W{1'b0}}, saturate(head_count)};
        end
        for (int i = 1; i < NST; i++) begin
            if (adv[i] && vld_reg[i-1]) begin
                dd_reg[i] <= dabble_group(dd_reg[i-1]);
            end
        end
        if (adv[NST] && vld_reg[NST-1]) begin
            seg_low_reg  <= {seg_code(bcd[15:12]), seg_code(bcd[11:8]),
                             seg_code(bcd[7:4]), seg_code(bcd[3:0])};
            seg_high_reg <= {seg_code(bcd[23:20]), seg_code(bcd[19:16])};
        end
    end

    assign m_valid         = out_vld_reg;
    assign m_seg_low_word  = seg_low_reg;
    assign m_seg_high_word = seg_high_reg;

endmodule

### rtl/core/button_counter_seven_segment.sv
// Top level of the button event counter with six-digit seven-segment output.
// Instantiates bcss_front, bcss_fifo and bcss_back; depends on bcss_pkg.
//
// Channel  Direction  Handshake           Payload
// s_       in         s_valid / s_ready   s_edge_bits[3:0], s_switch_value[9:0]
// m_       out        m_valid / m_ready   m_seg_low_word[31:0], m_seg_high_word[15:0]
//
// One event taken per cycle while s_ready is high; front-end count loop is registered.
// After its input transfer, a display word passes the FIFO, the saturate stage, five BCD
// stages of four shifts each, and the segment output register.
// Reset clears the count, the FIFO pointers and all pipeline valid bits.
// s_ready drops only when the FIFO is full; m_ready low stalls the pipeline stage by stage.
module button_counter_seven_segment
    import bcss_pkg::*;
#(
    parameter int FIFO_DEPTH = DEF_FIFO_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [EDGE_W-1:0]     s_edge_bits,
    input  logic [SWITCH_W-1:0]   s_switch_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SEG_LOW_W-1:0]  m_seg_low_word,
    output logic [SEG_HIGH_W-1:0] m_seg_high_word
);

    bcss_push_t         push;
    bcss_fifo_stat_t    fifo_stat;
    logic               pop;
    logic [COUNT_W-1:0] head_count;

    bcss_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_edge_bits    (s_edge_bits),
        .s_switch_value (s_switch_value),
        .fifo_stat      (fifo_stat),
        .push           (push)
    );

    bcss_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .pop        (pop),
        .head_count (head_count),
        .stat       (fifo_stat)
    );

    bcss_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_valid      (!fifo_stat.empty),
        .head_count      (head_count),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_seg_low_word  (m_seg_low_word),
        .m_seg_high_word (m_seg_high_word)
    );

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> !fifo_stat.full)
        else $error("Count pushed into a full FIFO.");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("Output valid or input stall after reset.");

    a_segment_packing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_seg_low_word[31] == 1'b0 && m_seg_low_word[23] == 1'b0 &&
                     m_seg_low_word[15] == 1'b0 && m_seg_low_word[7] == 1'b0 &&
                     m_seg_high_word[15] == 1'b0 && m_seg_high_word[7] == 1'b0))
        else $error("Segment byte has its unused top bit set.");

    a_pop_needs_data: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !fifo_stat.empty)
        else $error("Pipeline pulled from an empty FIFO.");

endmodule
